FILE: hdl/wmc_pkg.sv
// ----------------------------------------------------------------------------
// wmc_pkg
// Command codes and CORDIC constants shared by the world matrix compose block
// and its checker.
// ----------------------------------------------------------------------------
package wmc_pkg;

   typedef enum logic [1:0] {
      CMD_COMPOSE = 2'd0,
      CMD_PARENT  = 2'd1,
      CMD_LOAD    = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   localparam int CORDIC_STEPS = 30;
   localparam logic signed [31:0] CORDIC_K = 32'sd652032874;

   localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

endpackage

FILE: hdl/world_matrix_compose_top.sv
// ----------------------------------------------------------------------------
// world_matrix_compose_top
// Builds the 4x4 world matrix S * (Rz*Rx*Ry) * T, optionally times the stored
// parent matrix, and streams its sixteen elements row by row.
// ----------------------------------------------------------------------------
// A load command writes one parent element. A compose runs one CORDIC unit
// over the three angles in turn, then one 32x32 multiplier runs the matrix
// products at one product a cycle, four product matrices (five with the
// parent), and the sixteen beats leave at one a cycle when the result side
// does not stall. The block takes no new item until the last beat is loaded
// into the output register.
module world_matrix_compose_top #(
   parameter int FRAC_BITS  = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [3:0]         req_element_index,
   input  logic signed [31:0] req_element_value,
   input  logic signed [31:0] req_scale_x,
   input  logic signed [31:0] req_scale_y,
   input  logic signed [31:0] req_scale_z,
   input  logic [15:0]        req_angle_x,
   input  logic [15:0]        req_angle_y,
   input  logic [15:0]        req_angle_z,
   input  logic signed [31:0] req_translation_x,
   input  logic signed [31:0] req_translation_y,
   input  logic signed [31:0] req_translation_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_out_row,
   output logic [1:0]         rsp_out_col,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_clipped,
   output logic               rsp_last
);
   import wmc_pkg::*;

   localparam int CW  = 36;
   localparam int ZW  = 34;
   localparam int RSH = 30 - FRAC_BITS;
   localparam logic signed [CW-1:0] RHALF = (CW'(1) <<< RSH) >>> 1;
   localparam logic signed [63:0] PHALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] SMAX = 64'sd2147483647;
   localparam logic signed [63:0] SMIN = -64'sd2147483648;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CINIT, ST_CITER, ST_CDONE, ST_ISSUE, ST_DRAIN, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      PASS_ZX = 3'd0, PASS_Y = 3'd1, PASS_S = 3'd2, PASS_T = 3'd3, PASS_P = 3'd4
   } pass_type;

   typedef enum logic [1:0] {AX_X = 2'd0, AX_Y = 2'd1, AX_Z = 2'd2} axis_type;

   state_type          state_ff;
   pass_type           pass_ff;
   pass_type           last_pass_ff;
   axis_type           ang_sel_ff;
   logic [4:0]         step_ff;
   logic signed [CW-1:0] cx_ff;
   logic signed [CW-1:0] cy_ff;
   logic signed [ZW-1:0] cz_ff;
   logic               neg_ff;
   logic signed [31:0] sin_ff [3];
   logic signed [31:0] cos_ff [3];
   logic signed [31:0] scale_ff [3];
   logic signed [31:0] trans_ff [3];
   logic [15:0]        ang_ff [3];
   logic signed [31:0] parent_ff [16];
   logic signed [31:0] res_val_ff [32];
   logic               res_clip_ff [32];
   logic [5:0]         cnt_ff;
   logic               s1_v_ff;
   logic signed [31:0] s1_a_ff;
   logic signed [31:0] s1_b_ff;
   logic               s1_clip_ff;
   logic [5:0]         s1_tag_ff;
   logic               s2_v_ff;
   logic signed [63:0] s2_prod_ff;
   logic               s2_clip_ff;
   logic [5:0]         s2_tag_ff;
   logic signed [63:0] acc_ff;
   logic               acc_clip_ff;
   logic [3:0]         out_idx_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_row_ff;
   logic [1:0]         rsp_col_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_clip_ff;
   logic               rsp_last_ff;

   function automatic logic signed [31:0] rot_el(input axis_type ax, input logic [1:0] r,
                                                 input logic [1:0] c,
                                                 input logic signed [31:0] sn,
                                                 input logic signed [31:0] cs);
      logic signed [31:0] v;
      v = (r == c) ? ONE : 32'sd0;
      unique case (ax)
         AX_Z: begin
            if (r == 2'd0 && c == 2'd0) v = cs;
            else if (r == 2'd0 && c == 2'd1) v = sn;
            else if (r == 2'd1 && c == 2'd0) v = -sn;
            else if (r == 2'd1 && c == 2'd1) v = cs;
         end
         AX_X: begin
            if (r == 2'd1 && c == 2'd1) v = cs;
            else if (r == 2'd1 && c == 2'd2) v = sn;
            else if (r == 2'd2 && c == 2'd1) v = -sn;
            else if (r == 2'd2 && c == 2'd2) v = cs;
         end
         AX_Y: begin
            if (r == 2'd0 && c == 2'd0) v = cs;
            else if (r == 2'd0 && c == 2'd2) v = -sn;
            else if (r == 2'd2 && c == 2'd0) v = sn;
            else if (r == 2'd2 && c == 2'd2) v = cs;
         end
         default: v = v;
      endcase
      return v;
   endfunction

   logic [3:0]         iss_e;
   logic [1:0]         iss_k;
   logic [1:0]         iss_i;
   logic [1:0]         iss_j;
   logic [4:0]         rd_addr;
   logic signed [31:0] rd_val;
   logic               rd_clip;
   logic signed [31:0] op_a_in;
   logic signed [31:0] op_b_in;
   logic               op_clip_in;
   logic signed [31:0] scale_el;
   logic signed [31:0] trans_el;

   always_comb begin
      iss_e = cnt_ff[5:2];
      iss_k = cnt_ff[1:0];
      iss_i = iss_e[3:2];
      iss_j = iss_e[1:0];
      if (state_ff == ST_OUT) begin
         rd_addr = {last_pass_ff[0], out_idx_ff};
      end else if (pass_ff == PASS_S) begin
         rd_addr = {~pass_ff[0], iss_k, iss_j};
      end else begin
         rd_addr = {~pass_ff[0], iss_i, iss_k};
      end
      rd_val  = res_val_ff[rd_addr];
      rd_clip = res_clip_ff[rd_addr];
      scale_el = (iss_i == iss_k) ? ((iss_i == 2'd3) ? ONE : scale_ff[iss_i]) : 32'sd0;
      if (iss_k == 2'd3 && iss_j != 2'd3) begin
         trans_el = trans_ff[iss_j];
      end else begin
         trans_el = (iss_k == iss_j) ? ONE : 32'sd0;
      end
      unique case (pass_ff)
         PASS_ZX: op_a_in = rot_el(AX_Z, iss_i, iss_k, sin_ff[AX_Z], cos_ff[AX_Z]);
         PASS_S:  op_a_in = scale_el;
         default: op_a_in = rd_val;
      endcase
      unique case (pass_ff)
         PASS_ZX: op_b_in = rot_el(AX_X, iss_k, iss_j, sin_ff[AX_X], cos_ff[AX_X]);
         PASS_Y:  op_b_in = rot_el(AX_Y, iss_k, iss_j, sin_ff[AX_Y], cos_ff[AX_Y]);
         PASS_T:  op_b_in = trans_el;
         PASS_P:  op_b_in = parent_ff[{iss_k, iss_j}];
         default: op_b_in = rd_val;
      endcase
      op_clip_in = (pass_ff != PASS_ZX) && rd_clip;
   end

   logic signed [CW-1:0] dx_in;
   logic signed [CW-1:0] dy_in;
   logic signed [ZW-1:0] at_in;
   logic [ANGLE_BITS-1:0] ang_ext;
   logic [31:0]          ang32;
   logic                 fold_in;
   logic [31:0]          ang_fold;
   logic signed [CW-1:0] rc_in;
   logic signed [CW-1:0] rs_in;
   logic signed [31:0]   cos_in;
   logic signed [31:0]   sin_in;

   always_comb begin
      dx_in    = cy_ff >>> step_ff;
      dy_in    = cx_ff >>> step_ff;
      at_in    = ZW'(ATAN_TAB[step_ff]);
      ang_ext  = ANGLE_BITS'(ang_ff[ang_sel_ff]);
      ang32    = {ang_ext, {(32 - ANGLE_BITS){1'b0}}};
      fold_in  = (ang32[31:30] == 2'd1) || (ang32[31:30] == 2'd2);
      ang_fold = fold_in ? {~ang32[31], ang32[30:0]} : ang32;
      rc_in    = (cx_ff + RHALF) >>> RSH;
      rs_in    = (cy_ff + RHALF) >>> RSH;
      cos_in   = neg_ff ? -32'(rc_in) : 32'(rc_in);
      sin_in   = neg_ff ? -32'(rs_in) : 32'(rs_in);
   end

   logic signed [63:0] rnd_in;
   logic signed [63:0] sum_in;
   logic               sum_clip_in;
   logic signed [31:0] sat_in;
   logic               sat_clip_in;

   always_comb begin
      rnd_in      = (s2_prod_ff + PHALF) >>> FRAC_BITS;
      sum_in      = ((s2_tag_ff[1:0] == 2'd0) ? 64'sd0 : acc_ff) + rnd_in;
      sum_clip_in = ((s2_tag_ff[1:0] != 2'd0) && acc_clip_ff) || s2_clip_ff;
      priority if (sum_in > SMAX) begin
         sat_in      = 32'sh7FFFFFFF;
         sat_clip_in = 1'b1;
      end else if (sum_in < SMIN) begin
         sat_in      = 32'sh80000000;
         sat_clip_in = 1'b1;
      end else begin
         sat_in      = 32'(sum_in);
         sat_clip_in = sum_clip_in;
      end
   end

   logic req_take;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_ZX;
         last_pass_ff <= PASS_T;
         ang_sel_ff   <= AX_X;
         step_ff      <= '0;
         cnt_ff       <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < 16; n++) begin
            parent_ff[n] <= ((n >> 2) == (n & 3)) ? ONE : 32'sd0;
         end
      end else begin
         s1_v_ff    <= (state_ff == ST_ISSUE);
         s1_a_ff    <= op_a_in;
         s1_b_ff    <= op_b_in;
         s1_clip_ff <= op_clip_in;
         s1_tag_ff  <= cnt_ff;
         s2_v_ff    <= s1_v_ff;
         s2_prod_ff <= s1_a_ff * s1_b_ff;
         s2_clip_ff <= s1_clip_ff;
         s2_tag_ff  <= s1_tag_ff;
         if (s2_v_ff) begin
            acc_ff      <= sum_in;
            acc_clip_ff <= sum_clip_in;
            if (s2_tag_ff[1:0] == 2'd3) begin
               res_val_ff[{pass_ff[0], s2_tag_ff[5:2]}]  <= sat_in;
               res_clip_ff[{pass_ff[0], s2_tag_ff[5:2]}] <= sat_clip_in;
            end
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  unique case (cmd_type'(req_command))
                     CMD_LOAD: parent_ff[req_element_index] <= req_element_value;
                     CMD_COMPOSE, CMD_PARENT: begin
                        scale_ff[0]  <= req_scale_x;
                        scale_ff[1]  <= req_scale_y;
                        scale_ff[2]  <= req_scale_z;
                        trans_ff[0]  <= req_translation_x;
                        trans_ff[1]  <= req_translation_y;
                        trans_ff[2]  <= req_translation_z;
                        ang_ff[AX_X] <= req_angle_x;
                        ang_ff[AX_Y] <= req_angle_y;
                        ang_ff[AX_Z] <= req_angle_z;
                        last_pass_ff <= (cmd_type'(req_command) == CMD_PARENT) ? PASS_P
                                                                               : PASS_T;
                        ang_sel_ff   <= AX_X;
                        state_ff     <= ST_CINIT;
                     end
                     CMD_NONE: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_CINIT: begin
               cx_ff    <= CW'(CORDIC_K);
               cy_ff    <= '0;
               cz_ff    <= ZW'(signed'(ang_fold));
               neg_ff   <= fold_in;
               step_ff  <= '0;
               state_ff <= ST_CITER;
            end
            ST_CITER: begin
               if (!cz_ff[ZW-1]) begin
                  cx_ff <= cx_ff - dx_in;
                  cy_ff <= cy_ff + dy_in;
                  cz_ff <= cz_ff - at_in;
               end else begin
                  cx_ff <= cx_ff + dx_in;
                  cy_ff <= cy_ff - dy_in;
                  cz_ff <= cz_ff + at_in;
               end
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(CORDIC_STEPS - 1)) begin
                  state_ff <= ST_CDONE;
               end
            end
            ST_CDONE: begin
               sin_ff[ang_sel_ff] <= sin_in;
               cos_ff[ang_sel_ff] <= cos_in;
               unique case (ang_sel_ff)
                  AX_X: begin
                     ang_sel_ff <= AX_Y;
                     state_ff   <= ST_CINIT;
                  end
                  AX_Y: begin
                     ang_sel_ff <= AX_Z;
                     state_ff   <= ST_CINIT;
                  end
                  default: begin
                     pass_ff  <= PASS_ZX;
                     cnt_ff   <= '0;
                     state_ff <= ST_ISSUE;
                  end
               endcase
            end
            ST_ISSUE: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!s1_v_ff && !s2_v_ff) begin
                  if (pass_ff == last_pass_ff) begin
                     out_idx_ff <= '0;
                     state_ff   <= ST_OUT;
                  end else begin
                     unique case (pass_ff)
                        PASS_ZX: pass_ff <= PASS_Y;
                        PASS_Y:  pass_ff <= PASS_S;
                        PASS_S:  pass_ff <= PASS_T;
                        default: pass_ff <= PASS_P;
                     endcase
                     cnt_ff   <= '0;
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_row_ff   <= out_idx_ff[3:2];
                  rsp_col_ff   <= out_idx_ff[1:0];
                  rsp_value_ff <= rd_val;
                  rsp_clip_ff  <= rd_clip;
                  rsp_last_ff  <= (out_idx_ff == 4'd15);
                  out_idx_ff   <= out_idx_ff + 4'd1;
                  if (out_idx_ff == 4'd15) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_clipped   = rsp_clip_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

FILE: hdl/wmc_checker.sv
// ----------------------------------------------------------------------------
// wmc_checker
// Port-level checks for the world matrix compose block, bound to its top.
// ----------------------------------------------------------------------------
module wmc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [1:0]         req_command,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_out_row,
   input logic [1:0]         rsp_out_col,
   input logic signed [31:0] rsp_out_value,
   input logic               rsp_last
);
   import wmc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_value))
      else $error("stalled result beat changed");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_out_row == 2'd3 && rsp_out_col == 2'd3)))
      else $error("last flag not on final element");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid)
      else $error("beat follows last element at once");

   a_busy_after_compose: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_command == CMD_COMPOSE || req_command == CMD_PARENT) |=> req_stall)
      else $error("compose accepted without going busy");

endmodule

bind world_matrix_compose_top wmc_checker u_wmc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_command   (req_command),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_row   (rsp_out_row),
   .rsp_out_col   (rsp_out_col),
   .rsp_out_value (rsp_out_value),
   .rsp_last      (rsp_last)
);
